// ===== hdl/ozqd_pkg.sv =====
`default_nettype none

package ozqd_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_QPSK  = 2'd0;
  localparam mode_t MODE_QAM16 = 2'd1;
  localparam mode_t MODE_QAM64 = 2'd2;

  localparam logic [2:0] CNT_QPSK  = 3'd2;
  localparam logic [2:0] CNT_QAM16 = 3'd4;
  localparam logic [2:0] CNT_QAM64 = 3'd6;

  // squared thresholds: |x| > c/sqrt(d)  <=>  d*N^2 > c^2*P^2
  localparam int unsigned D_QAM16  = 10;
  localparam int unsigned D_QAM64  = 42;
  localparam int unsigned C2_INNER = 4;
  localparam int unsigned C2_MID   = 16;
  localparam int unsigned C2_OUTER = 36;

  typedef struct packed {
    logic nonneg;
    logic pos;
    logic gt_2_10;
    logic gt_2_42;
    logic gt_4_42;
    logic gt_6_42;
  } cmp_t;

endpackage

`default_nettype wire

// ===== hdl/ozqd_axis.sv =====
`default_nettype none

module ozqd_axis (
  input  wire ozqd_pkg::mode_t mode_i,
  input  wire ozqd_pkg::cmp_t  cmp_i,
  output logic [2:0]           bits_o
);

  always_comb begin
    case (mode_i)
      ozqd_pkg::MODE_QPSK: begin
        bits_o = {2'b00, cmp_i.nonneg};
      end
      ozqd_pkg::MODE_QAM16: begin
        bits_o = {1'b0, !cmp_i.gt_2_10, cmp_i.nonneg};
      end
      default: begin
        if (cmp_i.gt_4_42) begin
          bits_o = {!cmp_i.gt_6_42, 1'b0, cmp_i.pos};
        end else begin
          bits_o = {cmp_i.gt_2_42, 1'b1, cmp_i.pos};
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/ofdm_zf_equalize_hard_qam_demap.sv =====
// the result strobe follows the start cycle through seven register stages
// throughput: one subcarrier word per clock, busy is never raised
// the stages are: input, products, sums, magnitude, squares, scaling, decision
// reset clears the valid pipeline and sets the mode to qpsk
// the receiver cannot stall: every result is shown for exactly one cycle
`default_nettype none

module ofdm_zf_equalize_hard_qam_demap #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start,
  output logic                          busy,
  input  wire signed [SAMPLE_WIDTH-1:0] rx_real_i,
  input  wire signed [SAMPLE_WIDTH-1:0] rx_imag_i,
  input  wire signed [SAMPLE_WIDTH-1:0] chan_real_i,
  input  wire signed [SAMPLE_WIDTH-1:0] chan_imag_i,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire        [1:0]              cfg_data_i,
  output logic                          result_valid_o,
  output logic       [5:0]              hard_bits_o,
  output logic       [2:0]              bit_count_o,
  output logic                          zero_channel_o
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int PW  = 2 * W;
  localparam int NW  = 2 * W + 1;
  localparam int SQW = 4 * W;
  localparam int SCW = SQW + 6;

  ozqd_pkg::mode_t mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ozqd_pkg::MODE_QPSK;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  logic accept;
  assign accept = start && !busy;

  logic [6:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:1], accept};
    end
  end

  // stage 1: input word
  logic signed [W-1:0] yr1_q, yi1_q, hr1_q, hi1_q;
  ozqd_pkg::mode_t     mode1_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      yr1_q   <= rx_real_i;
      yi1_q   <= rx_imag_i;
      hr1_q   <= chan_real_i;
      hi1_q   <= chan_imag_i;
      mode1_q <= mode_q;
    end
  end

  // stage 2: products
  logic signed [PW-1:0] hryr2_q, hiyi2_q, hryi2_q, hiyr2_q, hrhr2_q, hihi2_q;
  ozqd_pkg::mode_t      mode2_q;

  always_ff @(posedge clk_i) begin
    hryr2_q <= PW'(hr1_q) * PW'(yr1_q);
    hiyi2_q <= PW'(hi1_q) * PW'(yi1_q);
    hryi2_q <= PW'(hr1_q) * PW'(yi1_q);
    hiyr2_q <= PW'(hi1_q) * PW'(yr1_q);
    hrhr2_q <= PW'(hr1_q) * PW'(hr1_q);
    hihi2_q <= PW'(hi1_q) * PW'(hi1_q);
    mode2_q <= mode1_q;
  end

  // stage 3: numerator and channel power
  logic signed [NW-1:0] nr3_q, ni3_q;
  logic        [PW-1:0] pw3_q;
  ozqd_pkg::mode_t      mode3_q;

  always_ff @(posedge clk_i) begin
    nr3_q   <= NW'(hryr2_q) + NW'(hiyi2_q);
    ni3_q   <= NW'(hryi2_q) - NW'(hiyr2_q);
    pw3_q   <= $unsigned(hrhr2_q) + $unsigned(hihi2_q);
    mode3_q <= mode2_q;
  end

  // stage 4: magnitudes and sign flags
  logic signed [NW-1:0] nr_neg, ni_neg;
  assign nr_neg = -nr3_q;
  assign ni_neg = -ni3_q;

  logic [PW-1:0]   nrm4_q, nim4_q, pw4_q;
  logic            nr_nonneg4_q, nr_pos4_q, ni_nonneg4_q, ni_pos4_q, zero4_q;
  ozqd_pkg::mode_t mode4_q;

  always_ff @(posedge clk_i) begin
    nrm4_q       <= nr3_q[NW-1] ? nr_neg[PW-1:0] : nr3_q[PW-1:0];
    nim4_q       <= ni3_q[NW-1] ? ni_neg[PW-1:0] : ni3_q[PW-1:0];
    pw4_q        <= pw3_q;
    nr_nonneg4_q <= !nr3_q[NW-1];
    nr_pos4_q    <= !nr3_q[NW-1] && (nr3_q != '0);
    ni_nonneg4_q <= !ni3_q[NW-1];
    ni_pos4_q    <= !ni3_q[NW-1] && (ni3_q != '0);
    zero4_q      <= (pw3_q == '0);
    mode4_q      <= mode3_q;
  end

  // stage 5: squares
  logic [SQW-1:0]  nr2_5_q, ni2_5_q, pw2_5_q;
  logic            nr_nonneg5_q, nr_pos5_q, ni_nonneg5_q, ni_pos5_q, zero5_q;
  ozqd_pkg::mode_t mode5_q;

  always_ff @(posedge clk_i) begin
    nr2_5_q      <= SQW'(nrm4_q) * SQW'(nrm4_q);
    ni2_5_q      <= SQW'(nim4_q) * SQW'(nim4_q);
    pw2_5_q      <= SQW'(pw4_q) * SQW'(pw4_q);
    nr_nonneg5_q <= nr_nonneg4_q;
    nr_pos5_q    <= nr_pos4_q;
    ni_nonneg5_q <= ni_nonneg4_q;
    ni_pos5_q    <= ni_pos4_q;
    zero5_q      <= zero4_q;
    mode5_q      <= mode4_q;
  end

  // stage 6: scaling by the threshold constants
  logic [SCW-1:0]  nr10_6_q, nr42_6_q, ni10_6_q, ni42_6_q;
  logic [SCW-1:0]  p4_6_q, p16_6_q, p36_6_q;
  logic            nr_nonneg6_q, nr_pos6_q, ni_nonneg6_q, ni_pos6_q, zero6_q;
  ozqd_pkg::mode_t mode6_q;

  always_ff @(posedge clk_i) begin
    nr10_6_q     <= SCW'(nr2_5_q) * SCW'(ozqd_pkg::D_QAM16);
    nr42_6_q     <= SCW'(nr2_5_q) * SCW'(ozqd_pkg::D_QAM64);
    ni10_6_q     <= SCW'(ni2_5_q) * SCW'(ozqd_pkg::D_QAM16);
    ni42_6_q     <= SCW'(ni2_5_q) * SCW'(ozqd_pkg::D_QAM64);
    p4_6_q       <= SCW'(pw2_5_q) * SCW'(ozqd_pkg::C2_INNER);
    p16_6_q      <= SCW'(pw2_5_q) * SCW'(ozqd_pkg::C2_MID);
    p36_6_q      <= SCW'(pw2_5_q) * SCW'(ozqd_pkg::C2_OUTER);
    nr_nonneg6_q <= nr_nonneg5_q;
    nr_pos6_q    <= nr_pos5_q;
    ni_nonneg6_q <= ni_nonneg5_q;
    ni_pos6_q    <= ni_pos5_q;
    zero6_q      <= zero5_q;
    mode6_q      <= mode5_q;
  end

  // stage 7: threshold compares and bit mapping
  ozqd_pkg::cmp_t cmp_re, cmp_im;
  logic [2:0]     bits_re, bits_im;

  always_comb begin
    cmp_re.nonneg  = nr_nonneg6_q;
    cmp_re.pos     = nr_pos6_q;
    cmp_re.gt_2_10 = nr10_6_q > p4_6_q;
    cmp_re.gt_2_42 = nr42_6_q > p4_6_q;
    cmp_re.gt_4_42 = nr42_6_q > p16_6_q;
    cmp_re.gt_6_42 = nr42_6_q > p36_6_q;
    cmp_im.nonneg  = ni_nonneg6_q;
    cmp_im.pos     = ni_pos6_q;
    cmp_im.gt_2_10 = ni10_6_q > p4_6_q;
    cmp_im.gt_2_42 = ni42_6_q > p4_6_q;
    cmp_im.gt_4_42 = ni42_6_q > p16_6_q;
    cmp_im.gt_6_42 = ni42_6_q > p36_6_q;
  end

  ozqd_axis u_axis_re (
    .mode_i (mode6_q),
    .cmp_i  (cmp_re),
    .bits_o (bits_re)
  );

  ozqd_axis u_axis_im (
    .mode_i (mode6_q),
    .cmp_i  (cmp_im),
    .bits_o (bits_im)
  );

  logic [5:0] bits_d;
  logic [2:0] count_d;

  always_comb begin
    case (mode6_q)
      ozqd_pkg::MODE_QPSK: begin
        bits_d  = {4'b0000, bits_im[0], bits_re[0]};
        count_d = ozqd_pkg::CNT_QPSK;
      end
      ozqd_pkg::MODE_QAM16: begin
        bits_d  = {2'b00, bits_im[1:0], bits_re[1:0]};
        count_d = ozqd_pkg::CNT_QAM16;
      end
      default: begin
        bits_d  = {bits_im, bits_re};
        count_d = ozqd_pkg::CNT_QAM64;
      end
    endcase
    if (zero6_q) begin
      bits_d = '0;
    end
  end

  logic [5:0] bits_q;
  logic [2:0] count_q;
  logic       zero_q;

  always_ff @(posedge clk_i) begin
    bits_q  <= bits_d;
    count_q <= count_d;
    zero_q  <= zero6_q;
  end

  logic vld_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[6];
    end
  end

  assign result_valid_o = vld_out_q;

  assign hard_bits_o    = bits_q;
  assign bit_count_o    = count_q;
  assign zero_channel_o = zero_q;

endmodule

`default_nettype wire
